FILE: src/ir_pulse_width_transmitter_top_assert.svh
// ----------------------------------------------------------------------------
// IR pulse-width transmitter assertion macros
// Concurrent assertion wrappers used by the RTL; empty when NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_WIDTH_TRANSMITTER_TOP_ASSERT_SVH
`define IR_PULSE_WIDTH_TRANSMITTER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define IRPWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define IRPWT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IRPWT_ASSERT(lbl, prop, msg)

`define IRPWT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: src/irpwt_pkg.sv
// ----------------------------------------------------------------------------
// IR pulse-width transmitter package
// Shared types and constants for the transmitter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package irpwt_pkg;

  localparam int unsigned BIT_COUNT_DEF = 16;

  localparam int unsigned CHUNK_W = 6;
  localparam int unsigned TICK_W  = 12;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned DAC_W   = 12;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned TOP_W   = 16;
  localparam int unsigned CMP_W   = 15;
  localparam int unsigned PROD_W  = CMP_W + PCT_W;

  localparam logic [TOP_W-1:0]  CARRIER_TOP_RST = 16'd1799;

  localparam logic [TICK_W-1:0] HEADER_MARK_TICKS = 12'd2400;
  localparam logic [TICK_W-1:0] ONE_MARK_TICKS    = 12'd1200;
  localparam logic [TICK_W-1:0] SHORT_TICKS       = 12'd600;

  localparam logic [PCT_W-1:0]  PCT_MAX = 7'd100;

  // floor(x / 100) == (x * DIV_MUL) >> DIV_SHIFT for x < 2**22
  localparam int unsigned       DIV_MUL_W = 23;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 23'd5368710;
  localparam int unsigned       DIV_SHIFT = 29;
  localparam int unsigned       DIV_FULL_W = PROD_W + DIV_MUL_W;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_TICK  = 1'b1
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [WORD_W-1:0]  data_word;
    logic [DAC_W-1:0]   dac_current;
    logic [PCT_W-1:0]   pwm_percent;
  } item_t;

  typedef struct packed {
    logic               mark_on;
    logic [PROD_W-1:0]  prod;
    logic [DAC_W-1:0]   dac_level;
    logic               busy_res;
    logic               tx_done;
  } mid_t;

endpackage

`default_nettype wire

FILE: src/irpwt_seq.sv
// ----------------------------------------------------------------------------
// IR pulse-width transmitter chunk sequencer
// Holds the transmission state and advances it by one transaction per cycle while the result side accepts.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_pulse_width_transmitter_top_assert.svh"

module irpwt_seq #(
  parameter int unsigned BIT_COUNT = irpwt_pkg::BIT_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [irpwt_pkg::TOP_W-1:0] carrier_top,
  input  wire logic                        item_valid,
  input  wire irpwt_pkg::item_t            item,
  output logic                             item_ready,
  output logic                             mid_valid,
  output irpwt_pkg::mid_t                  mid,
  input  wire logic                        mid_ready
);

  localparam logic [irpwt_pkg::CHUNK_W-1:0] LAST_CHUNK =
    irpwt_pkg::CHUNK_W'(2 * BIT_COUNT + 1);

  function automatic logic is_mark(input logic [irpwt_pkg::CHUNK_W-1:0] k);
    is_mark = (k != irpwt_pkg::CHUNK_W'(1)) && !k[0];
  endfunction

  logic [irpwt_pkg::CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [irpwt_pkg::TICK_W-1:0]  tick_r, tick_nxt, tick_inc, dur;
  logic [irpwt_pkg::WORD_W-1:0]  shift_r, shift_nxt;
  logic [irpwt_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic [irpwt_pkg::DAC_W-1:0]   drive_r, drive_nxt;
  logic                          active_r, active_nxt;
  logic                          done;
  logic [irpwt_pkg::PCT_W-1:0]   pct_sat;
  logic                          load;
  logic                          mid_valid_r, mid_valid_nxt;
  irpwt_pkg::mid_t               mid_r, mid_nxt;

  assign item_ready = !mid_valid_r || mid_ready;
  assign load       = item_valid && item_ready;
  assign mid_valid  = mid_valid_r;
  assign mid        = mid_r;

  assign pct_sat  = (item.pwm_percent > irpwt_pkg::PCT_MAX) ? irpwt_pkg::PCT_MAX
                                                            : item.pwm_percent;
  assign tick_inc = tick_r + irpwt_pkg::TICK_W'(1);

  always_comb begin
    if (chunk_r == '0) begin
      dur = irpwt_pkg::HEADER_MARK_TICKS;
    end else if (is_mark(chunk_r) && shift_r[irpwt_pkg::WORD_W-1]) begin
      dur = irpwt_pkg::ONE_MARK_TICKS;
    end else begin
      dur = irpwt_pkg::SHORT_TICKS;
    end
  end

  always_comb begin
    chunk_nxt  = chunk_r;
    tick_nxt   = tick_r;
    shift_nxt  = shift_r;
    prod_nxt   = prod_r;
    drive_nxt  = drive_r;
    active_nxt = active_r;
    done       = 1'b0;
    if (load) begin
      if (item.func == irpwt_pkg::FUNC_START) begin
        shift_nxt  = item.data_word;
        drive_nxt  = item.dac_current;
        prod_nxt   = irpwt_pkg::PROD_W'(carrier_top[irpwt_pkg::TOP_W-1:1]) *
                     irpwt_pkg::PROD_W'(pct_sat);
        chunk_nxt  = '0;
        tick_nxt   = '0;
        active_nxt = 1'b1;
      end else if (active_r) begin
        if (tick_inc >= dur) begin
          tick_nxt = '0;
          if (chunk_r >= LAST_CHUNK) begin
            active_nxt = 1'b0;
            done       = 1'b1;
          end else begin
            chunk_nxt = chunk_r + irpwt_pkg::CHUNK_W'(1);
          end
          if (chunk_r != '0 && is_mark(chunk_r)) begin
            shift_nxt = {shift_r[irpwt_pkg::WORD_W-2:0], 1'b0};
          end
        end else begin
          tick_nxt = tick_inc;
        end
      end
    end
  end

  always_comb begin
    mid_nxt.mark_on   = active_nxt && is_mark(chunk_nxt);
    mid_nxt.prod      = mid_nxt.mark_on ? prod_nxt : '0;
    mid_nxt.dac_level = mid_nxt.mark_on ? drive_nxt : '0;
    mid_nxt.busy_res  = active_nxt;
    mid_nxt.tx_done   = done;
    mid_valid_nxt     = item_ready ? item_valid : mid_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r     <= '0;
      tick_r      <= '0;
      shift_r     <= '0;
      prod_r      <= '0;
      drive_r     <= '0;
      active_r    <= 1'b0;
      mid_valid_r <= 1'b0;
    end else begin
      chunk_r     <= chunk_nxt;
      tick_r      <= tick_nxt;
      shift_r     <= shift_nxt;
      prod_r      <= prod_nxt;
      drive_r     <= drive_nxt;
      active_r    <= active_nxt;
      mid_valid_r <= mid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mid_r <= mid_nxt;
    end
  end

  `IRPWT_ASSERT(a_done_ends_busy, mid_valid_r && mid_r.tx_done |-> !mid_r.busy_res, "done while busy")
  `IRPWT_ASSERT(a_mark_needs_busy, mid_valid_r && mid_r.mark_on |-> mid_r.busy_res, "mark while idle")
  `IRPWT_ASSERT(a_chunk_range, active_r |-> chunk_r <= LAST_CHUNK, "chunk index out of range")
  `IRPWT_ASSERT(a_tick_range, tick_r < irpwt_pkg::HEADER_MARK_TICKS, "tick count overrun")
  `IRPWT_ASSERT(a_idle_holds, !active_r && !(load && item.func == irpwt_pkg::FUNC_START) |=> !active_r, "spurious restart")

endmodule

`default_nettype wire

FILE: src/irpwt_scale.sv
// ----------------------------------------------------------------------------
// IR pulse-width transmitter compare scaling and result register
// Divides the duty product by 100 and holds the result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module irpwt_scale (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            mid_valid,
  input  wire irpwt_pkg::mid_t mid,
  output logic                 mid_ready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [31:0]          out_tdata  // mark_on, pwm_compare, dac_level, busy_res, tx_done
);

  logic [irpwt_pkg::DIV_FULL_W-1:0] q_full;
  logic [irpwt_pkg::CMP_W-1:0]      cmp_r;
  logic [irpwt_pkg::DAC_W-1:0]      dac_r;
  logic                             mark_r, busy_r, done_r;
  logic                             valid_r, valid_nxt;

  assign mid_ready = !valid_r || out_tready;
  assign valid_nxt = mid_ready ? mid_valid : valid_r;
  assign q_full    = irpwt_pkg::DIV_FULL_W'(mid.prod) *
                     irpwt_pkg::DIV_FULL_W'(irpwt_pkg::DIV_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_valid && mid_ready) begin
      cmp_r  <= q_full[irpwt_pkg::DIV_SHIFT +: irpwt_pkg::CMP_W];
      dac_r  <= mid.dac_level;
      mark_r <= mid.mark_on;
      busy_r <= mid.busy_res;
      done_r <= mid.tx_done;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {2'b00, done_r, busy_r, dac_r, cmp_r, mark_r};

endmodule

`default_nettype wire

FILE: src/ir_pulse_width_transmitter_top.sv
// ----------------------------------------------------------------------------
// IR pulse-width transmitter top level
// Pulse-width coded IR word transmitter with carrier duty and DAC drive.
// ----------------------------------------------------------------------------
// One transaction is taken every clock cycle while the result side keeps up.
// Each produces exactly one result, and out_tvalid rises after it passes all
// stages. There are three register stages: an input register, the chunk
// sequencer stage (with the duty product multiplier) and the divide-by-100
// reciprocal multiplier in front of the result register.
// Write carrier_top only while no transaction is in flight.
`default_nettype none

module ir_pulse_width_transmitter_top #(
  parameter int unsigned BIT_COUNT = irpwt_pkg::BIT_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,  // carrier_top
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,     // data_word, dac_current, pwm_percent
  input  wire logic        in_tuser,     // func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata     // mark_on, pwm_compare, dac_level, busy_res, tx_done
);

  logic [irpwt_pkg::TOP_W-1:0] carrier_top_r;
  logic                        s1_valid_r, s1_valid_nxt;
  irpwt_pkg::item_t            s1_item_r;
  logic                        s1_ready;
  logic                        mid_valid, mid_ready;
  irpwt_pkg::mid_t             mid;

  assign in_tready    = !s1_valid_r || s1_ready;
  assign s1_valid_nxt = in_tready ? in_tvalid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_top_r <= irpwt_pkg::CARRIER_TOP_RST;
      s1_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        carrier_top_r <= cfg_wr_data;
      end
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.func        <= irpwt_pkg::func_t'(in_tuser);
      s1_item_r.data_word   <= in_tdata[15:0];
      s1_item_r.dac_current <= in_tdata[27:16];
      s1_item_r.pwm_percent <= in_tdata[34:28];
    end
  end

  irpwt_seq #(
    .BIT_COUNT(BIT_COUNT)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .carrier_top(carrier_top_r),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .item_ready (s1_ready),
    .mid_valid  (mid_valid),
    .mid        (mid),
    .mid_ready  (mid_ready)
  );

  irpwt_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_valid (mid_valid),
    .mid       (mid),
    .mid_ready (mid_ready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire
